// ===== hdl/ordered_array_list_engine_macros.svh =====
// Assertion helpers for the list engine top file.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ORDERED_ARRAY_LIST_ENGINE_MACROS_SVH
`define ORDERED_ARRAY_LIST_ENGINE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OALE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OALE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/oale_pkg.sv =====
`default_nettype none

package oale_pkg;

  // Default list capacity and fixed field widths.
  localparam int unsigned CAPACITY_DEF = 256;
  localparam int unsigned POS_W        = 9;
  localparam int unsigned ELEM_W       = 32;
  // Number of cells folded by one first-level reduction group.
  localparam int unsigned GRP_SIZE     = 16;

  // Operation codes of an input item.
  typedef enum logic [3:0] {
    OP_PUSH_FRONT = 4'd0,
    OP_PUSH_BACK  = 4'd1,
    OP_INSERT     = 4'd2,
    OP_POP_FRONT  = 4'd3,
    OP_POP_BACK   = 4'd4,
    OP_DEL_POS    = 4'd5,
    OP_DEL_VALUE  = 4'd6,
    OP_LOCATE     = 4'd7,
    OP_GET        = 4'd8,
    OP_CLEAR      = 4'd9,
    OP_REVERSE    = 4'd10
  } op_e;

  // Status codes of a result item.
  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_FULL      = 3'd1,
    STS_EMPTY     = 3'd2,
    STS_BAD_POS   = 3'd3,
    STS_NOT_FOUND = 3'd4
  } status_e;

  // What every cell of the row does in a given cycle.
  typedef enum logic [2:0] {
    CELL_HOLD  = 3'd0,
    CELL_OPEN  = 3'd1,
    CELL_CLOSE = 3'd2,
    CELL_CLEAR = 3'd3,
    CELL_SWAP  = 3'd4
  } cell_op_e;

  // Broadcast control common to all cells.
  typedef struct packed {
    cell_op_e                 op;
    logic                     phase;
    logic signed [ELEM_W-1:0] value;
  } cell_ctrl_t;

  typedef struct packed {
    op_e                      op;
    logic [POS_W-1:0]         position;
    logic signed [ELEM_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_e                  status;
    logic signed [ELEM_W-1:0] elem_out;
    logic [POS_W-1:0]         found_position;
    logic [POS_W-1:0]         list_length;
    logic                     is_empty;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hdl/oale_cell.sv =====
`default_nettype none

module oale_cell import oale_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned INDEX    = 0
) (
  input  wire logic                            clk_i,
  input  wire cell_ctrl_t                      ctrl_i,
  input  wire logic [$clog2(CAPACITY)-1:0]     at_i,
  input  wire logic [$clog2(CAPACITY)-1:0]     sel_i,
  input  wire logic [$clog2(CAPACITY+1)-1:0]   cnt_i,
  input  wire logic signed [ELEM_W-1:0]        left_i,
  input  wire logic signed [ELEM_W-1:0]        right_i,
  output logic signed [ELEM_W-1:0]             data_o,
  output logic                                 hit_o,
  output logic signed [ELEM_W-1:0]             rd_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] K     = CW'(INDEX);
  localparam logic [CW-1:0] K_P1  = CW'(INDEX + 1);
  localparam logic          K_ODD = 1'(INDEX % 2);

  logic signed [ELEM_W-1:0] data_q, data_d;
  logic [CW-1:0]            at_x;
  logic [CW-1:0]            sel_x;

  assign at_x  = CW'(at_i);
  assign sel_x = CW'(sel_i);

  // Next element: hold, take from a neighbour, load the new value or clear.
  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      CELL_OPEN: begin
        if (K == at_x) begin
          data_d = ctrl_i.value;
        end else if ((K > at_x) && (K <= cnt_i)) begin
          data_d = left_i;
        end
      end
      CELL_CLOSE: begin
        if (K_P1 == cnt_i) begin
          data_d = '0;
        end else if ((K >= at_x) && (K_P1 < cnt_i)) begin
          data_d = right_i;
        end
      end
      CELL_CLEAR: begin
        data_d = '0;
      end
      CELL_SWAP: begin
        // Pairs start at cells whose parity matches the phase.
        if (K_ODD == ctrl_i.phase) begin
          if (K_P1 < cnt_i) begin
            data_d = right_i;
          end
        end else if ((INDEX != 0) && (K < cnt_i)) begin
          data_d = left_i;
        end
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // Search match, limited to occupied cells, and the addressed read.
  assign hit_o  = (K < cnt_i) && (data_q == ctrl_i.value);
  assign rd_o   = (K == sel_x) ? data_q : '0;
  assign data_o = data_q;

endmodule

`default_nettype wire

// ===== hdl/oale_grp.sv =====
`default_nettype none

module oale_grp import oale_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned BASE     = 0
) (
  input  wire logic                          clk_i,
  input  wire logic                          hit_i [GRP_SIZE],
  input  wire logic signed [ELEM_W-1:0]      rd_i  [GRP_SIZE],
  output logic                               any_o,
  output logic [$clog2(CAPACITY)-1:0]        first_o,
  output logic [$clog2(CAPACITY)-1:0]        last_o,
  output logic signed [ELEM_W-1:0]           rd_o
);

  localparam int unsigned IW = $clog2(CAPACITY);

  logic                     any_d, any_q;
  logic [IW-1:0]            first_d, first_q;
  logic [IW-1:0]            last_d, last_q;
  logic signed [ELEM_W-1:0] rd_d, rd_q;

  // First and last match of the group and the OR of the addressed read.
  always_comb begin
    any_d   = 1'b0;
    first_d = '0;
    last_d  = '0;
    rd_d    = '0;
    for (int j = GRP_SIZE - 1; j >= 0; j--) begin
      if (hit_i[j]) begin
        first_d = IW'(BASE + j);
      end
    end
    for (int j = 0; j < GRP_SIZE; j++) begin
      if (hit_i[j]) begin
        last_d = IW'(BASE + j);
        any_d  = 1'b1;
      end
      rd_d = rd_d | rd_i[j];
    end
  end

  always_ff @(posedge clk_i) begin
    any_q   <= any_d;
    first_q <= first_d;
    last_q  <= last_d;
    rd_q    <= rd_d;
  end

  assign any_o   = any_q;
  assign first_o = first_q;
  assign last_o  = last_q;
  assign rd_o    = rd_q;

endmodule

`default_nettype wire

// ===== hdl/ordered_array_list_engine.sv =====
// Push, insert, clear, reverse of fewer than two elements and unused codes go from acceptance
// straight to the result state; pops, deletes, get and searches first pass the two-level
// registered group reduction (S_GRP, S_SUM). Reverse of n >= 2 first runs its swap rounds.
// The sequencer holds one item at a time, so a new item is taken only after the last result
// is registered, and a result that the receiver has not taken holds the sequencer until it is taken.
// Reset clears the element count, the sequencer and the output valid flag only.
`default_nettype none

`include "ordered_array_list_engine_macros.svh"

module ordered_array_list_engine import oale_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int unsigned NG = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GRP  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_REV  = 3'd4;

  logic [2:0]               state_q, state_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [CW-1:0]            rev_q, rev_d;
  logic                     phase_q, phase_d;
  op_e                      op_q;
  logic [POS_W-1:0]         pos_q;
  logic signed [ELEM_W-1:0] val_q;
  out_item_t                out_q;
  logic                     out_valid_q;

  logic                     in_fire;
  logic                     exec_fire;
  logic                     scan_op;

  // Cell row and reduction wiring.
  logic signed [ELEM_W-1:0] cell_data [CAPACITY];
  logic                     hit_v [NG][GRP_SIZE];
  logic signed [ELEM_W-1:0] rd_v  [NG][GRP_SIZE];
  logic                     grp_any   [NG];
  logic [IW-1:0]            grp_first [NG];
  logic [IW-1:0]            grp_last  [NG];
  logic signed [ELEM_W-1:0] grp_rd    [NG];

  logic                     sum_any_d, sum_any_q;
  logic [IW-1:0]            sum_first_d, sum_first_q;
  logic [IW-1:0]            sum_last_d, sum_last_q;
  logic signed [ELEM_W-1:0] sum_rd_d, sum_rd_q;

  cell_ctrl_t               cell_ctrl;
  cell_op_e                 ex_op;
  logic [IW-1:0]            ex_at;
  logic [IW-1:0]            rd_idx;
  logic [CW-1:0]            cnt_nx;
  logic [CW-1:0]            cnt_m1;
  logic [XW-1:0]            pos_x, cnt_x, pos_m1_x, fpos_x, len_x;
  logic                     pos_ok, list_full, list_empty;
  out_item_t                res;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign exec_fire  = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  // Position arithmetic in a width that holds both the field and the count.
  assign pos_x      = XW'(pos_q);
  assign cnt_x      = XW'(cnt_q);
  assign pos_m1_x   = pos_x - XW'(1);
  assign cnt_m1     = cnt_q - CW'(1);
  assign pos_ok     = (pos_x != '0) && (pos_x <= cnt_x);
  assign list_full  = (cnt_q == CAP_C);
  assign list_empty = (cnt_q == '0);

  // Ops that need the search or an addressed read before they complete.
  always_comb begin
    case (in_item_i.op) inside
      OP_POP_FRONT, OP_POP_BACK, OP_DEL_POS, OP_DEL_VALUE, OP_LOCATE, OP_GET: begin
        scan_op = 1'b1;
      end
      default: begin
        scan_op = 1'b0;
      end
    endcase
  end

  // Index of the element a read op returns.
  always_comb begin
    unique case (op_q)
      OP_POP_BACK:        rd_idx = cnt_m1[IW-1:0];
      OP_DEL_POS, OP_GET: rd_idx = pos_m1_x[IW-1:0];
      default:            rd_idx = '0;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    rev_d   = rev_q;
    phase_d = phase_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if ((in_item_i.op == OP_REVERSE) && (cnt_q >= CW'(2))) begin
            state_d = S_REV;
            rev_d   = cnt_q;
            phase_d = 1'b0;
          end else if (scan_op) begin
            state_d = S_GRP;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_GRP: begin
        state_d = S_SUM;
      end
      S_SUM: begin
        state_d = S_EXEC;
      end
      S_REV: begin
        rev_d   = rev_q - CW'(1);
        phase_d = ~phase_q;
        if (rev_q == CW'(1)) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result and cell command for the completing op.
  always_comb begin
    res            = '0;
    res.status     = STS_OK;
    res.elem_out   = '0;
    fpos_x         = '0;
    ex_op          = CELL_HOLD;
    ex_at          = '0;
    cnt_nx         = cnt_q;
    unique case (op_q)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (list_full) begin
          res.status = STS_FULL;
        end else begin
          ex_op  = CELL_OPEN;
          ex_at  = (op_q == OP_PUSH_FRONT) ? '0 : cnt_q[IW-1:0];
          cnt_nx = cnt_q + CW'(1);
        end
      end
      OP_INSERT: begin
        if ((pos_x == '0) || (pos_x > (cnt_x + XW'(1)))) begin
          res.status = STS_BAD_POS;
        end else if (list_full) begin
          res.status = STS_FULL;
        end else begin
          ex_op  = CELL_OPEN;
          ex_at  = pos_m1_x[IW-1:0];
          cnt_nx = cnt_q + CW'(1);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (list_empty) begin
          res.status = STS_EMPTY;
        end else begin
          res.elem_out = sum_rd_q;
          ex_op        = CELL_CLOSE;
          ex_at        = (op_q == OP_POP_FRONT) ? '0 : cnt_m1[IW-1:0];
          cnt_nx       = cnt_m1;
        end
      end
      OP_DEL_POS: begin
        if (!pos_ok) begin
          res.status = STS_BAD_POS;
        end else begin
          res.elem_out = sum_rd_q;
          ex_op        = CELL_CLOSE;
          ex_at        = pos_m1_x[IW-1:0];
          cnt_nx       = cnt_m1;
        end
      end
      OP_DEL_VALUE: begin
        if (!sum_any_q) begin
          res.status = STS_NOT_FOUND;
        end else begin
          res.elem_out = val_q;
          fpos_x       = XW'(sum_first_q) + XW'(1);
          ex_op        = CELL_CLOSE;
          ex_at        = sum_first_q;
          cnt_nx       = cnt_m1;
        end
      end
      OP_LOCATE: begin
        if (!sum_any_q) begin
          res.status = STS_NOT_FOUND;
        end else begin
          res.elem_out = val_q;
          fpos_x       = XW'(sum_last_q) + XW'(1);
        end
      end
      OP_GET: begin
        if (!pos_ok) begin
          res.status = STS_BAD_POS;
        end else begin
          res.elem_out = sum_rd_q;
        end
      end
      OP_CLEAR: begin
        ex_op  = CELL_CLEAR;
        cnt_nx = '0;
      end
      default: begin
        // Reverse has already run its swap rounds; unused codes do nothing.
        ex_op = CELL_HOLD;
      end
    endcase
    len_x              = XW'(cnt_nx);
    res.found_position = fpos_x[POS_W-1:0];
    res.list_length    = len_x[POS_W-1:0];
    res.is_empty       = (cnt_nx == '0);
  end

  assign cnt_d = exec_fire ? cnt_nx : cnt_q;

  // Broadcast to the cell row.
  always_comb begin
    cell_ctrl.phase = phase_q;
    cell_ctrl.value = val_q;
    if (exec_fire) begin
      cell_ctrl.op = ex_op;
    end else if (state_q == S_REV) begin
      cell_ctrl.op = CELL_SWAP;
    end else begin
      cell_ctrl.op = CELL_HOLD;
    end
  end

  // Row of element cells, each wired to its two neighbours.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [ELEM_W-1:0] left_w, right_w;
    if (k == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_body
      assign left_w = cell_data[k-1];
    end
    if (k == CAPACITY - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_next
      assign right_w = cell_data[k+1];
    end
    oale_cell #(
      .CAPACITY (CAPACITY),
      .INDEX    (k)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .at_i    (ex_at),
      .sel_i   (rd_idx),
      .cnt_i   (cnt_q),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[k]),
      .hit_o   (hit_v[k / GRP_SIZE][k % GRP_SIZE]),
      .rd_o    (rd_v[k / GRP_SIZE][k % GRP_SIZE])
    );
  end

  // Unused leaves of the last group.
  for (genvar k = CAPACITY; k < NG * GRP_SIZE; k++) begin : g_pad
    assign hit_v[k / GRP_SIZE][k % GRP_SIZE] = 1'b0;
    assign rd_v[k / GRP_SIZE][k % GRP_SIZE]  = '0;
  end

  // First level of the registered reduction.
  for (genvar g = 0; g < NG; g++) begin : g_grp
    oale_grp #(
      .CAPACITY (CAPACITY),
      .BASE     (g * GRP_SIZE)
    ) u_grp (
      .clk_i   (clk_i),
      .hit_i   (hit_v[g]),
      .rd_i    (rd_v[g]),
      .any_o   (grp_any[g]),
      .first_o (grp_first[g]),
      .last_o  (grp_last[g]),
      .rd_o    (grp_rd[g])
    );
  end

  // Second level: combine the group results.
  always_comb begin
    sum_any_d   = 1'b0;
    sum_first_d = '0;
    sum_last_d  = '0;
    sum_rd_d    = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        sum_first_d = grp_first[g];
      end
    end
    for (int g = 0; g < NG; g++) begin
      if (grp_any[g]) begin
        sum_last_d = grp_last[g];
        sum_any_d  = 1'b1;
      end
      sum_rd_d = sum_rd_d | grp_rd[g];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_SUM) begin
      sum_any_q   <= sum_any_d;
      sum_first_q <= sum_first_d;
      sum_last_q  <= sum_last_d;
      sum_rd_q    <= sum_rd_d;
    end
  end

  // Captured item.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= in_item_i.op;
      pos_q <= in_item_i.position;
      val_q <= in_item_i.value;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      out_q <= res;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rev_q       <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rev_q   <= rev_d;
      phase_q <= phase_d;
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Checks on the sequencer and the element count.
  `OALE_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_q <= CAP_C, "element count above capacity")
  `OALE_ASSERT_NEXT(a_clear_empties, exec_fire && (op_q == OP_CLEAR), cnt_q == '0, "clear left elements")
  `OALE_ASSERT_SAME(a_rev_rounds, state_q == S_REV, rev_q != '0, "swap round with no rounds left")
  `OALE_ASSERT_NEXT(a_push_grows, exec_fire && (op_q == OP_PUSH_BACK) && !list_full, cnt_q == ($past(cnt_q) + CW'(1)), "push did not grow the list")
  `OALE_ASSERT_NEXT(a_one_item, in_fire, !in_ready_o, "second item taken while one is in work")

endmodule

`default_nettype wire
